/* rtl/core/dpm_pkg.sv */
package dpm_pkg;

  localparam int unsigned DigitsDefault = 8;
  localparam int unsigned CandW = 27;
  localparam int unsigned NibW = 6;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TARGET_UPPER  = 2'd0,
    CFG_TARGET_LOWER  = 2'd1,
    CFG_MATCH_NIBBLES = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md5_st_t;

  function automatic logic [31:0] md5_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    return k[i];
  endfunction

  function automatic logic [4:0] md5_s(input logic [5:0] i);
    logic [4:0] s [16];
    s = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
          5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
    return s[{i[5:4], i[1:0]}];
  endfunction

  function automatic logic [3:0] md5_g(input logic [5:0] i);
    logic [3:0] r;
    case (i[5:4])
      2'd0:    r = i[3:0];
      2'd1:    r = 4'(5 * i + 1);
      2'd2:    r = 4'(3 * i + 5);
      default: r = 4'(7 * i);
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] t;
    t = {x, x} << s;
    return t[63:32];
  endfunction

  // one md5 round, round number fixed per stage
  function automatic md5_st_t md5_round(input md5_st_t st, input logic [5:0] i,
                                        input logic [31:0] w);
    logic [31:0] f;
    md5_st_t r;
    case (i[5:4])
      2'd0:    f = (st.b & st.c) | (~st.b & st.d);
      2'd1:    f = (st.d & st.b) | (~st.d & st.c);
      2'd2:    f = st.b ^ st.c ^ st.d;
      default: f = st.c ^ (st.b | ~st.d);
    endcase
    r.a = st.d;
    r.d = st.c;
    r.c = st.b;
    r.b = st.b + rotl(st.a + f + md5_k(i) + w, md5_s(i));
    return r;
  endfunction

endpackage

/* rtl/core/decimal_pin_md5_match.sv */
// decimal_pin_md5_match
// request channel: candidate_i with in_valid_i / in_ready_o. each candidate
// is rendered as DIGITS zero-padded ascii digits, hashed with md5 and the
// leading match_nibbles nibbles of the digest compared with the target.
// result channel: hit_o and candidate_out_o with out_valid_o / out_ready_i.
// configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
// index 0 target upper, 1 target lower, 2 match nibbles; others ignored.
// write only while no request is in flight.
// throughput: one request per cycle while the output is not stalled. the
// result passes through DIGITS + 66 register stages (digit stages, 64 md5
// round stages, compare stage, output register; the first stage loads at
// the accepting edge).
// the whole pipeline advances together; when the receiver stalls the
// output register holds and the pipeline freezes, so nothing is lost.
// reset clears all valid bits and loads the targets with zero and the
// nibble count with 32.
module decimal_pin_md5_match #(
  parameter int unsigned DIGITS = dpm_pkg::DigitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [dpm_pkg::CandW-1:0]    candidate_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         hit_o,
  output logic [dpm_pkg::CandW-1:0]    candidate_out_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [dpm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [63:0]                  cfg_data_i
);
  import dpm_pkg::*;

  logic [63:0]       tgt_up_q, tgt_lo_q;
  logic [NibW-1:0]   nib_q;
  logic              en;
  logic              d_vld, p_vld, p_hit;
  logic [CandW-1:0]  d_cand, p_cand;
  logic [DIGITS*8-1:0] d_txt;
  logic              o_vld_q, o_hit_q;
  logic [CandW-1:0]  o_cand_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_up_q <= '0;
      tgt_lo_q <= '0;
      nib_q    <= NibW'(32);
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TARGET_UPPER:  tgt_up_q <= cfg_data_i;
        CFG_TARGET_LOWER:  tgt_lo_q <= cfg_data_i;
        CFG_MATCH_NIBBLES: nib_q    <= cfg_data_i[NibW-1:0];
        default: ;
      endcase
    end
  end

  // advance unless a finished result waits and the receiver is not ready
  assign en = !o_vld_q || out_ready_i;
  assign in_ready_o = en;

  dpm_digits #(.DIGITS(DIGITS)) u_digits (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(in_valid_i), .cand_i(candidate_i),
    .valid_o(d_vld), .cand_o(d_cand), .text_o(d_txt)
  );

  dpm_md5 #(.DIGITS(DIGITS)) u_md5 (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(d_vld), .cand_i(d_cand), .text_i(d_txt),
    .target_i({tgt_up_q, tgt_lo_q}), .nibbles_i(nib_q),
    .valid_o(p_vld), .cand_o(p_cand), .hit_o(p_hit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else if (en) begin
      o_vld_q <= p_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_hit_q  <= p_hit;
      o_cand_q <= p_cand;
    end
  end

  assign out_valid_o     = o_vld_q;
  assign hit_o           = o_hit_q;
  assign candidate_out_o = o_cand_q;

endmodule

/* rtl/core/dpm_digits.sv */
// decimal conversion, one digit per stage: peels the low digit off by
// multiply with reciprocal of ten, registered each step
module dpm_digits #(
  parameter int unsigned DIGITS = dpm_pkg::DigitsDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [dpm_pkg::CandW-1:0]  cand_i,
  output logic                       valid_o,
  output logic [dpm_pkg::CandW-1:0]  cand_o,
  output logic [DIGITS*8-1:0]        text_o
);
  import dpm_pkg::*;

  localparam int unsigned RecipW = 32;
  // ceil(2^35/10) exact for quotients of 27 bit values
  localparam logic [RecipW-1:0] Recip = 32'hCCCCCCCD;

  logic [DIGITS:0]             vld_q;
  logic [CandW-1:0]            rem_q  [DIGITS+1];
  logic [CandW-1:0]            cand_q [DIGITS+1];
  logic [DIGITS*8-1:0]         txt_q  [DIGITS+1];

  always_comb begin
    vld_q[0]  = valid_i;
    rem_q[0]  = cand_i;
    cand_q[0] = cand_i;
    txt_q[0]  = '0;
  end

  for (genvar s = 0; s < DIGITS; s++) begin : g_dig
    logic [CandW+RecipW-1:0] prod;
    logic [CandW-1:0]        quo;
    logic [3:0]              dg;
    logic [DIGITS*8-1:0]     txt_d;
    assign prod = {{RecipW{1'b0}}, rem_q[s]} * {{CandW{1'b0}}, Recip};
    assign quo  = CandW'(prod >> 35);
    assign dg   = 4'(rem_q[s] - CandW'(quo * 4'd10));

    // byte position DIGITS-1-s, packed byte 0 at low end
    always_comb begin
      txt_d = txt_q[s];
      txt_d[(DIGITS-1-s)*8 +: 8] = {4'h3, dg};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= quo;
        cand_q[s+1] <= cand_q[s];
        txt_q[s+1]  <= txt_d;
      end
    end
  end

  assign valid_o = vld_q[DIGITS];
  assign cand_o  = cand_q[DIGITS];
  assign text_o  = txt_q[DIGITS];

endmodule

/* rtl/core/dpm_md5.sv */
// 64 round md5 pipeline, one round per stage, plus compare stage
module dpm_md5 #(
  parameter int unsigned DIGITS = dpm_pkg::DigitsDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [dpm_pkg::CandW-1:0]  cand_i,
  input  logic [DIGITS*8-1:0]        text_i,
  input  logic [127:0]               target_i,
  input  logic [dpm_pkg::NibW-1:0]   nibbles_i,
  output logic                       valid_o,
  output logic [dpm_pkg::CandW-1:0]  cand_o,
  output logic                       hit_o
);
  import dpm_pkg::*;

  localparam int unsigned Rounds = 64;
  localparam logic [63:0] BitLen = 64'(DIGITS * 8);

  logic [Rounds:0]   vld_q;
  md5_st_t           st_q   [Rounds+1];
  logic [CandW-1:0]  cand_q [Rounds+1];
  logic [511:0]      blk_q  [Rounds+1];
  logic [511:0]      blk0;

  // message block, byte n at bits 8n
  always_comb begin
    blk0 = '0;
    blk0[DIGITS*8-1:0] = text_i;
    blk0[DIGITS*8 +: 8] = 8'h80;
    blk0[511:448] = BitLen;
  end

  always_comb begin
    vld_q[0]  = valid_i;
    st_q[0]   = '{a: 32'h67452301, b: 32'hefcdab89, c: 32'h98badcfe, d: 32'h10325476};
    cand_q[0] = cand_i;
    blk_q[0]  = blk0;
  end

  for (genvar r = 0; r < Rounds; r++) begin : g_rnd
    localparam logic [5:0] Idx = 6'(r);
    logic [31:0] w;
    assign w = blk_q[r][md5_g(Idx)*32 +: 32];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[r+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[r+1] <= vld_q[r];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[r+1]   <= md5_round(st_q[r], Idx, w);
        cand_q[r+1] <= cand_q[r];
        blk_q[r+1]  <= blk_q[r];
      end
    end
  end

  logic [127:0] dig;
  logic [127:0] tgt;
  logic [31:0]  nib_eq;
  logic         hit;
  md5_st_t      fin;

  assign fin.a = st_q[Rounds].a + 32'h67452301;
  assign fin.b = st_q[Rounds].b + 32'hefcdab89;
  assign fin.c = st_q[Rounds].c + 32'h98badcfe;
  assign fin.d = st_q[Rounds].d + 32'h10325476;

  // digest bytes in little-endian word order, flip to byte 0 at the top
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      dig[127-8*i -: 8] = (i < 4)  ? fin.a[8*(i%4) +: 8] :
                          (i < 8)  ? fin.b[8*(i%4) +: 8] :
                          (i < 12) ? fin.c[8*(i%4) +: 8] : fin.d[8*(i%4) +: 8];
    end
    tgt = target_i;
    hit = 1'b1;
    for (int n = 0; n < 32; n++) begin
      nib_eq[n] = dig[127-4*n -: 4] == tgt[127-4*n -: 4];
      if (NibW'(n) < nibbles_i && !nib_eq[n]) hit = 1'b0;
    end
    if (nibbles_i > NibW'(32)) hit = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= vld_q[Rounds];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cand_o <= cand_q[Rounds];
      hit_o  <= hit;
    end
  end

endmodule
